// File: src/cmv_pkg.sv
package cmv_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int IDX_W = 10;
  localparam int CFG_W = 11;
  localparam int DATA_W = 32;
  localparam int SUM_W = 48;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int EFF_W = ($clog2(MAX_LENGTH + 1) > CFG_W) ? $clog2(MAX_LENGTH + 1) : CFG_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSPOSE = 2'd0,
    CFG_VEC_LEN   = 2'd1,
    CFG_ROWS      = 2'd2,
    CFG_COLUMNS   = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  typedef struct packed {
    logic capture;
    logic vec_write;
    logic trip_read;
    logic slot_read;
    logic mul;
    logic acc_write;
    logic set_bad;
    logic out_load;
    logic read_clear;
    logic clear_write;
  } cmv_cmd_t;

  typedef struct packed {
    func_t func;
    logic  slot_ok;
    logic  trip_ok;
    logic  clear_last;
  } cmv_stat_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [ADDR_W+IDX_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic [EFF_W-1:0] to_eff(input logic [IDX_W-1:0] idx);
    logic [EFF_W+IDX_W-1:0] wide;
    wide = {{EFF_W{1'b0}}, idx};
    return wide[EFF_W-1:0];
  endfunction

endpackage

// File: src/cmv_ctrl.sv
module cmv_ctrl
  import cmv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cmv_stat_t stat,
  output cmv_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_ACC,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.func)
          FUNC_LOAD: begin
            cmd.vec_write = stat.slot_ok;
            state_next = S_IDLE;
          end
          FUNC_ACCUM: begin
            if (stat.trip_ok) begin
              cmd.trip_read = 1'b1;
              state_next = S_MUL;
            end else begin
              cmd.set_bad = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_READ: begin
            cmd.slot_read = 1'b1;
            state_next = S_READ;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_write = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.read_clear = stat.slot_ok;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/cmv_datapath.sv
module cmv_datapath
  import cmv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmv_cmd_t                 cmd,
  output cmv_stat_t                stat,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [1:0]               func,
  input  logic [IDX_W-1:0]         slot,
  input  logic [IDX_W-1:0]         entry_row,
  input  logic [IDX_W-1:0]         entry_column,
  input  logic signed [DATA_W-1:0] data_word,
  output logic [IDX_W-1:0]         result_slot,
  output logic signed [SUM_W-1:0]  result_sum,
  output logic [1:0]               status
);

  logic                     transpose_mode;
  logic [CFG_W-1:0]         vector_length;
  logic [CFG_W-1:0]         matrix_rows;
  logic [CFG_W-1:0]         matrix_columns;

  logic [1:0]               it_func;
  logic [IDX_W-1:0]         it_slot;
  logic [IDX_W-1:0]         it_row;
  logic [IDX_W-1:0]         it_col;
  logic signed [DATA_W-1:0] it_data;

  logic signed [DATA_W-1:0] vector_store [MAX_LENGTH];
  logic signed [SUM_W-1:0]  sum_store [MAX_LENGTH];
  logic signed [DATA_W-1:0] vec_rd;
  logic signed [SUM_W-1:0]  sum_rd;
  logic signed [PROD_W-1:0] prod;
  logic [ADDR_W-1:0]        clr_cnt;
  logic                     bad_index_seen;

  logic [EFF_W-1:0]         eff_len;
  logic [IDX_W-1:0]         tgt;
  logic [IDX_W-1:0]         src;
  logic                     mismatch;
  logic signed [SUM_W:0]    acc_wide;
  logic signed [SUM_W-1:0]  acc_sat;
  logic                     sum_we;
  logic [ADDR_W-1:0]        sum_waddr;
  logic signed [SUM_W-1:0]  sum_wdata;

  always_comb begin
    if (EFF_W'(vector_length) < EFF_W'(MAX_LENGTH)) begin
      eff_len = EFF_W'(vector_length);
    end else begin
      eff_len = EFF_W'(MAX_LENGTH);
    end
  end

  assign tgt = transpose_mode ? it_col : it_row;
  assign src = transpose_mode ? it_row : it_col;
  assign mismatch = transpose_mode ? (vector_length != matrix_columns)
                                   : (vector_length != matrix_rows);

  assign stat.func = func_t'(it_func);
  assign stat.slot_ok = to_eff(it_slot) < eff_len;
  assign stat.trip_ok = ({1'b0, it_row} < matrix_rows) && ({1'b0, it_col} < matrix_columns)
                        && (to_eff(tgt) < eff_len) && (to_eff(src) < eff_len);
  assign stat.clear_last = (clr_cnt == ADDR_W'(MAX_LENGTH - 1));

  // Product is floored to Q32.16 by dropping its low fraction bits.
  assign acc_wide = {sum_rd[SUM_W-1], sum_rd} + {prod[PROD_W-1], prod[PROD_W-1:FRAC_W]};

  always_comb begin
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_we = 1'b0;
    sum_waddr = clr_cnt;
    sum_wdata = '0;
    if (cmd.clear_write) begin
      sum_we = 1'b1;
    end else if (cmd.acc_write) begin
      sum_we = 1'b1;
      sum_waddr = to_addr(tgt);
      sum_wdata = acc_sat;
    end else if (cmd.read_clear) begin
      sum_we = 1'b1;
      sum_waddr = to_addr(it_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_mode <= 1'b0;
      vector_length <= CFG_W'(1024);
      matrix_rows <= CFG_W'(1024);
      matrix_columns <= CFG_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRANSPOSE: transpose_mode <= cfg_data[0];
        CFG_VEC_LEN: vector_length <= cfg_data;
        CFG_ROWS: matrix_rows <= cfg_data;
        CFG_COLUMNS: matrix_columns <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      bad_index_seen <= 1'b0;
    end else begin
      if (cmd.clear_write) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.set_bad) begin
        bad_index_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func <= func;
      it_slot <= slot;
      it_row <= entry_row;
      it_col <= entry_column;
      it_data <= data_word;
    end
    if (cmd.mul) begin
      prod <= it_data * vec_rd;
    end
    if (cmd.out_load) begin
      result_slot <= it_slot;
      if (mismatch) begin
        result_sum <= '0;
        status <= ST_MISMATCH;
      end else begin
        result_sum <= stat.slot_ok ? sum_rd : '0;
        status <= bad_index_seen ? ST_BAD : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_write) begin
      vector_store[to_addr(it_slot)] <= it_data;
    end
    if (cmd.trip_read) begin
      vec_rd <= vector_store[to_addr(src)];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_store[sum_waddr] <= sum_wdata;
    end
    if (cmd.trip_read) begin
      sum_rd <= sum_store[to_addr(tgt)];
    end else if (cmd.slot_read) begin
      sum_rd <= sum_store[to_addr(it_slot)];
    end
  end

endmodule

// File: src/coo_sparse_matrix_vector_multiply_unit.sv
// Sparse matrix times dense vector in coordinate form, with Q16.16 data and
// 48-bit saturating Q32.16 sums. After reset the block first clears its sum
// memory, one entry per cycle; no transaction is taken on the input channel
// during that pass, while configuration writes are taken at once.
// Items are handled one at a time by a state machine around single-port-write
// memories: a vector load is captured and then written; a triplet is captured,
// read from memory, multiplied, then accumulated and written back; a read is
// captured, read, and held until the output register is free to take it.
// Configuration must be written only while the block is idle.
module coo_sparse_matrix_vector_multiply_unit
  import cmv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic [IDX_W-1:0]         slot,
  input  logic [IDX_W-1:0]         entry_row,
  input  logic [IDX_W-1:0]         entry_column,
  input  logic signed [DATA_W-1:0] data_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         result_slot,
  output logic signed [SUM_W-1:0]  result_sum,
  output logic [1:0]               status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  cmv_cmd_t  cmd;
  cmv_stat_t stat;

  assign cfg_ready = 1'b1;

  cmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmv_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .slot         (slot),
    .entry_row    (entry_row),
    .entry_column (entry_column),
    .data_word    (data_word),
    .result_slot  (result_slot),
    .result_sum   (result_sum),
    .status       (status)
  );

endmodule
